[hw/rtl/halton_radical_inverse_core_macros.svh]
// ----------------------------------------------------------------------------
// Halton radical inverse core - assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef HALTON_RADICAL_INVERSE_CORE_MACROS_SVH
`define HALTON_RADICAL_INVERSE_CORE_MACROS_SVH

// same-cycle implication
`define HRI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hri_pkg.sv]
// ----------------------------------------------------------------------------
// hri_pkg
// Widths, request/response types and job format of the radical inverse core.
// ----------------------------------------------------------------------------
package hri_pkg;

  localparam int INDEX_BITS = 32;
  localparam int FRAC_BITS  = 32;
  localparam int BASE_BITS  = 8;

  // digit divider consumes one chunk of the index per cycle
  localparam int CHUNK_BITS = 8;
  localparam int NUM_CHUNKS = (INDEX_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PAD_BITS   = NUM_CHUNKS * CHUNK_BITS;
  localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  // base^digits stays below 2^(INDEX_BITS+BASE_BITS)
  localparam int PROD_BITS  = INDEX_BITS + BASE_BITS;
  localparam int FCNT_W     = $clog2(FRAC_BITS);

  localparam int MIN_BASE   = 2;

  // queue between front and back, power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [INDEX_BITS-1:0] sample_index;
    logic [BASE_BITS-1:0]  base;
  } hri_req_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] fraction;
    logic                 bad_base;
  } hri_rsp_t;

  typedef enum logic [1:0] {
    CLS_RUN,
    CLS_ZERO,
    CLS_BAD
  } hri_cls_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0] sample_index;
    logic [BASE_BITS-1:0]  base;
    logic [CHUNK_W-1:0]    top;   // highest nonzero chunk of the index
    hri_cls_e              cls;
  } hri_job_t;

endpackage

[hw/rtl/hri_front.sv]
// ----------------------------------------------------------------------------
// hri_front
// Request intake: classifies the request and finds the index's top chunk.
// ----------------------------------------------------------------------------
module hri_front (
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  hri_pkg::hri_req_t req_i,
  input  logic              full_i,
  output logic              push_o,
  output hri_pkg::hri_job_t job_o
);
  import hri_pkg::*;

  logic [PAD_BITS-1:0] idx_pad;
  logic [CHUNK_W-1:0]  top;

  assign idx_pad = PAD_BITS'(req_i.sample_index);

  always_comb begin
    top = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      if (idx_pad[c*CHUNK_BITS +: CHUNK_BITS] != '0) begin
        top = CHUNK_W'(c);
      end
    end
  end

  always_comb begin
    job_o.sample_index = req_i.sample_index;
    job_o.base         = req_i.base;
    job_o.top          = top;
    if (req_i.base < BASE_BITS'(MIN_BASE)) begin
      job_o.cls = CLS_BAD;
    end else if (req_i.sample_index == '0) begin
      job_o.cls = CLS_ZERO;
    end else begin
      job_o.cls = CLS_RUN;
    end
  end

  assign req_ready_o = !full_i;
  assign push_o      = req_valid_i && !full_i;

endmodule

[hw/rtl/hri_fifo.sv]
// ----------------------------------------------------------------------------
// hri_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`include "halton_radical_inverse_core_macros.svh"

module hri_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hri_pkg::hri_job_t job_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output hri_pkg::hri_job_t job_o
);
  import hri_pkg::*;

  hri_job_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   cnt_q;
  logic                    do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `HRI_ASSERT_IMPL(a_fifo_cnt_bound, 1'b1, cnt_q <= FIFO_CNT_W'(FIFO_DEPTH), "fifo overfilled")
  `HRI_ASSERT_IMPL(a_fifo_no_push_full, full_o, !push_i, "push into full fifo")
  `HRI_ASSERT_NEXT(a_fifo_last_pop, do_pop && !push_i && cnt_q == FIFO_CNT_W'(1), !valid_o, "fifo not empty after last pop")

endmodule

[hw/rtl/hri_back.sv]
// ----------------------------------------------------------------------------
// hri_back
// Digit engine: chunked digit division, mirrored accumulation, final
// fraction division, and the response register.
// ----------------------------------------------------------------------------
`include "halton_radical_inverse_core_macros.svh"

module hri_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  hri_pkg::hri_job_t job_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output hri_pkg::hri_rsp_t rsp_o
);
  import hri_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIG,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  hri_cls_e               cls_q;
  logic [BASE_BITS-1:0]   base_q;
  logic [PAD_BITS-1:0]    x_q;      // index, quotient chunks overwrite in place
  logic [CHUNK_W-1:0]     cnt_q;
  logic [CHUNK_W-1:0]     top_q;
  logic                   topz_q;   // quotient chunk at top was zero
  logic [BASE_BITS-1:0]   rem_q;
  logic [BASE_BITS-1:0]   dig_q;
  logic                   pend_q;   // dig_q waits to be folded into r/p
  logic [PROD_BITS-1:0]   r_q;      // mirrored digits, later the remainder
  logic [PROD_BITS-1:0]   p_q;      // base^digits
  logic [FRAC_BITS-1:0]   q_q;
  logic [FCNT_W-1:0]      fcnt_q;
  logic                   out_valid_q;
  hri_rsp_t               out_q;

  logic [BASE_BITS-1:0]   div_rem;
  logic [CHUNK_BITS-1:0]  div_qc;
  logic [CHUNK_W-1:0]     next_top;
  logic [PROD_BITS+BASE_BITS-1:0] r_prod;
  logic [PROD_BITS+BASE_BITS-1:0] p_prod;
  logic [PROD_BITS-1:0]   acc_r;
  logic [PROD_BITS-1:0]   acc_p;
  logic [PROD_BITS:0]     dv_t;
  logic [PROD_BITS:0]     dv_sub;
  logic                   dv_ge;
  logic                   out_load;

  // one chunk of restoring division by the base
  always_comb begin
    logic [BASE_BITS:0]    t;
    logic [BASE_BITS-1:0]  r;
    logic [CHUNK_BITS-1:0] c;
    r = rem_q;
    c = x_q[cnt_q*CHUNK_BITS +: CHUNK_BITS];
    div_qc = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      t = {r, c[i]};
      if (t >= {1'b0, base_q}) begin
        t = t - {1'b0, base_q};
        div_qc[i] = 1'b1;
      end
      r = t[BASE_BITS-1:0];
    end
    div_rem = r;
  end

  // quotient loses its top chunk only when that chunk came out zero
  assign next_top = (topz_q && top_q != '0) ? top_q - 1'b1 : top_q;

  assign r_prod = r_q * base_q;
  assign p_prod = p_q * base_q;
  assign acc_r  = r_prod[PROD_BITS-1:0] + PROD_BITS'(dig_q);
  assign acc_p  = p_prod[PROD_BITS-1:0];

  // final division, one quotient bit per cycle
  assign dv_t   = {r_q, 1'b0};
  assign dv_ge  = (dv_t >= {1'b0, p_q});
  assign dv_sub = dv_t - {1'b0, p_q};

  // response register takes a new result when empty or draining
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pend_q <= (state_q == ST_DIG) && (cnt_q == '0);
      if (pend_q) begin
        r_q <= acc_r;
        p_q <= acc_p;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            cls_q   <= job_i.cls;
            base_q  <= job_i.base;
            x_q     <= PAD_BITS'(job_i.sample_index);
            cnt_q   <= job_i.top;
            top_q   <= job_i.top;
            topz_q  <= 1'b0;
            rem_q   <= '0;
            r_q     <= '0;
            p_q     <= PROD_BITS'(1);
            state_q <= (job_i.cls == CLS_RUN) ? ST_DIG : ST_DONE;
          end
        end
        ST_DIG: begin
          x_q[cnt_q*CHUNK_BITS +: CHUNK_BITS] <= div_qc;
          if (cnt_q == top_q) begin
            topz_q <= (div_qc == '0);
          end
          if (cnt_q == '0) begin
            dig_q  <= div_rem;
            rem_q  <= '0;
            if (top_q == '0 && div_qc == '0) begin
              state_q <= ST_FIN;
            end else begin
              top_q <= next_top;
              cnt_q <= next_top;
            end
          end else begin
            rem_q <= div_rem;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FIN: begin
          // last digit is folded in this cycle
          q_q     <= '0;
          fcnt_q  <= FCNT_W'(FRAC_BITS - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          r_q <= dv_ge ? dv_sub[PROD_BITS-1:0] : dv_t[PROD_BITS-1:0];
          q_q <= {q_q[FRAC_BITS-2:0], dv_ge};
          if (fcnt_q == '0) begin
            state_q <= ST_DONE;
          end else begin
            fcnt_q <= fcnt_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_q.fraction    <= (cls_q == CLS_RUN) ? q_q : '0;
            out_q.bad_base    <= (cls_q == CLS_BAD);
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign job_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `HRI_ASSERT_IMPL(a_dig_rem_lt_base, state_q == ST_DIG, rem_q < base_q, "digit remainder not below base")
  `HRI_ASSERT_IMPL(a_div_rem_lt_div, state_q == ST_DIV, r_q < p_q, "fraction remainder not below divisor")
  `HRI_ASSERT_IMPL(a_bad_base_zero, out_valid_q && out_q.bad_base, out_q.fraction == '0, "bad base with nonzero fraction")

endmodule

[hw/rtl/halton_radical_inverse_core.sv]
// ----------------------------------------------------------------------------
// Halton radical inverse core
// Returns the radical inverse of a sample index in a given radix as an
// unsigned 0.32 fraction, floor(2^32 * sum of d_k / base^(k+1)), exact and
// truncated. Index 0 gives 0; a base of 0 or 1 gives 0 with bad_base set.
// Each request yields exactly one response, in order. The front classifies
// requests and queues up to two jobs, so requests can still be taken while
// the engine works and while a finished response waits in its output
// register, until the queue is full. A job passes through the queue, then
// the engine's digit states, a fold state and the fraction division states,
// and then the response register. The digit divider handles 8 index bits a
// cycle for each digit, and the final fraction divider one bit a cycle. Bad
// bases and index 0 skip both dividers. The engine works on one request at a
// time and takes no new job until its result is loaded into the response
// register; a response held off by the receiver stalls the engine in its
// done state.
// ----------------------------------------------------------------------------
module halton_radical_inverse_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  hri_pkg::hri_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output hri_pkg::hri_rsp_t rsp_o
);
  import hri_pkg::*;

  hri_job_t push_job;
  hri_job_t pop_job;
  logic     push;
  logic     full;
  logic     job_valid;
  logic     job_ready;

  // front: classify (bad base / zero index / run) and find top index chunk
  hri_front u_front (
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // decoupling queue
  hri_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_ready),
    .job_o   (pop_job)
  );

  // back: digit extraction, mirrored fold, fraction divide, response reg
  hri_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (pop_job),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

[sim/hri_rsp_checker.sv]
// ----------------------------------------------------------------------------
// hri_rsp_checker
// Watches the request and response channels of the radical inverse core.
// Works out the exact 0.32 radical inverse for every accepted request and
// compares it, field by field, with the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hri_rsp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  hri_pkg::hri_req_t req_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  hri_pkg::hri_rsp_t rsp_i,
  output int                mismatch_cnt_o,
  output int                outstanding_o
);
  import hri_pkg::*;

  hri_rsp_t expected_rsp_q[$];
  int       mismatches = 0;

  // Digits are taken least significant first, then folded back from the
  // deepest mirrored position: q = floor((d * 2^F + q) / b). Nested floors
  // stay exact, so q ends as floor(2^F * sum). d * 2^F + q fits in 64 bits.
  function automatic hri_rsp_t radical_inverse(input hri_req_t r);
    logic [63:0]          rest;
    logic [63:0]          radix;
    logic [63:0]          q;
    logic [BASE_BITS-1:0] digit [INDEX_BITS];
    int                   cnt;
    hri_rsp_t             res;
    res   = '0;
    radix = 64'(r.base);
    if (r.base < MIN_BASE) begin
      res.bad_base = 1'b1;
      return res;
    end
    rest = 64'(r.sample_index);
    cnt  = 0;
    q    = '0;
    while (rest != 0 && cnt < INDEX_BITS) begin
      digit[cnt] = BASE_BITS'(rest % radix);
      rest       = rest / radix;
      cnt++;
    end
    for (int k = cnt - 1; k >= 0; k--)
      q = ((64'(digit[k]) << FRAC_BITS) + q) / radix;
    res.fraction = q[FRAC_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    hri_rsp_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i)
        expected_rsp_q.push_back(radical_inverse(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding: fraction %h bad_base %b",
                 rsp_i.fraction, rsp_i.bad_base);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.fraction !== want.fraction) begin
            $error("fraction mismatch: expected %h, got %h", want.fraction, rsp_i.fraction);
            mismatches++;
          end
          if (rsp_i.bad_base !== want.bad_base) begin
            $error("bad_base mismatch: expected %b, got %b", want.bad_base, rsp_i.bad_base);
            mismatches++;
          end
        end
      end
    end
    mismatch_cnt_o <= mismatches;
    outstanding_o  <= expected_rsp_q.size();
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives sample index / radix requests into the radical inverse core with
// random gaps and response back-pressure, plus one long response hold-off and
// one full drain. The checker beside the core predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hri_pkg::*;

  localparam int RAND_ITEMS  = 650;
  localparam int CALM_ITEMS  = 60;    // tail of the run with no idling at all
  localparam int HOLD_AT     = 150;   // random request that triggers the hold-off
  localparam int DRAIN_AT    = 400;   // random request that waits for a full drain
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 150;
  // No handshake at all for this long means the core is stuck. The longest
  // legal quiet stretch is the hold-off plus one worst-case request.
  localparam int STALL_LIMIT = 4000;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     req_valid_i;
  logic     req_ready_o;
  hri_req_t req_i;
  logic     rsp_valid_o;
  logic     rsp_ready_i;
  hri_rsp_t rsp_o;

  int mismatch_cnt;
  int outstanding;
  int stall_cycles = 0;

  bit calm     = 1'b0;   // set for the tail: both sides stop idling
  bit hold_ask = 1'b0;   // sender asks the receiver for one long hold-off

  always #6 clk_i = ~clk_i;

  halton_radical_inverse_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  hri_rsp_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_ready_i    (req_ready_o),
    .req_i          (req_i),
    .rsp_valid_i    (rsp_valid_o),
    .rsp_ready_i    (rsp_ready_i),
    .rsp_i          (rsp_o),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding)
  );

  // Offer one request and hold it until taken; then maybe a short gap.
  task automatic offer(input logic [INDEX_BITS-1:0] idx, input logic [BASE_BITS-1:0] radix);
    req_i.sample_index <= idx;
    req_i.base         <= radix;
    req_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Sampled on the falling edge so the count is settled; returns on a rising edge.
  task automatic wait_all_answered();
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  // Random request: mostly valid radices, indices spread over magnitudes and
  // around digit-count boundaries (powers of the radix and one below).
  task automatic offer_random();
    logic [BASE_BITS-1:0]  radix;
    logic [INDEX_BITS-1:0] idx;
    logic [63:0]           pow;
    int                    pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)       radix = BASE_BITS'($urandom_range(0, 1));
    else if (pick < 15) radix = BASE_BITS'(2);
    else if (pick < 40) radix = BASE_BITS'($urandom_range(2, 16));
    else                radix = BASE_BITS'($urandom_range(2, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      idx = $urandom;
    end else if (pick < 70) begin
      idx = $urandom >> $urandom_range(0, 31);
    end else if (pick < 85) begin
      idx = $urandom_range(0, 1000);
    end else begin
      pow = 64'd1;
      if (radix >= MIN_BASE)
        repeat ($urandom_range(1, 32))
          if (pow * radix <= 64'hFFFF_FFFF) pow = pow * radix;
      idx = INDEX_BITS'(pow - 64'($urandom_range(0, 1)));
    end
    offer(idx, radix);
  endtask

  // Response side: ready in random runs, random stall bursts, one long hold-off.
  initial begin : response_side
    rsp_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        rsp_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        rsp_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any accepted request or response resets the count.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : request_side
    rst_ni      <= 1'b0;
    req_valid_i <= 1'b0;
    req_i       <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: invalid radices, index zero, field extremes, digit boundaries.
    offer('0, 8'd2);
    offer('0, 8'd0);
    offer('1, 8'd0);
    offer(32'h1234_5678, 8'd1);
    offer('0, 8'd1);
    offer('1, 8'd2);              // base 2, full index: longest run
    offer(32'd1, 8'd2);           // one half
    offer(32'h8000_0000, 8'd2);
    offer('1, 8'd255);
    offer('1, 8'd254);
    offer(32'd1, 8'd255);
    offer(32'd254, 8'd255);       // single top digit
    offer(32'd255, 8'd255);       // first two-digit index
    offer(32'd3, 8'd3);
    offer(32'hFFFF_FFFE, 8'd3);
    offer(32'h0000_00FF, 8'd128);
    offer(32'h0001_0000, 8'd127);
    offer(32'hAAAA_AAAA, 8'd16);
    offer(32'h5555_5555, 8'd10);
    offer(32'd1, 8'd7);
    offer('0, 8'd255);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == HOLD_AT) hold_ask = 1'b1;
      if (n == DRAIN_AT) begin
        // sender pause: nothing new until every response is back
        req_valid_i <= 1'b0;
        wait_all_answered();
      end
      offer_random();
    end
    req_valid_i <= 1'b0;

    wait_all_answered();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
